// ----- rtl/bkve_pkg.sv -----
`default_nettype none

package bkve_pkg;

    localparam int MAX_TEXT_BYTES_DEF = 2048;
    localparam int FIFO_DEPTH = 4;
    localparam logic [2:0] KEY_LEN = 3'd5;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_NUL   = 8'h00;

    typedef enum logic [2:0] {
        PH_LEAD,
        PH_KEY,
        PH_AFTER_KEY,
        PH_AFTER_EQ,
        PH_VALUE,
        PH_SKIP_LINE,
        PH_DONE
    } phase_t;

    typedef struct packed {
        logic [7:0] path_byte;
        logic       last_of_path;
        logic       found;
    } res_t;

    // Up to two results are produced by one input transfer, already packed
    // so that the first valid result is always in the first slot.
    typedef struct packed {
        logic [1:0] count;
        res_t       first;
        res_t       second;
    } push_t;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR);
    endfunction

    function automatic logic [7:0] key_char(input logic [2:0] pos);
        logic [7:0] ch;
        unique case (pos)
            3'd0:    ch = 8'h42; // B
            3'd1:    ch = 8'h4F; // O
            3'd2:    ch = 8'h4F; // O
            3'd3:    ch = 8'h54; // T
            3'd4:    ch = 8'h32; // 2
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/bkve_parser.sv -----
`default_nettype none

module bkve_parser #(
    parameter int MAX_TEXT_BYTES = bkve_pkg::MAX_TEXT_BYTES_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            take,
    input  wire logic [7:0]      text_byte,
    input  wire logic            final_byte,
    output bkve_pkg::push_t      push
);
    import bkve_pkg::*;

    localparam int CNT_W = $clog2(MAX_TEXT_BYTES + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_TEXT_BYTES);

    phase_t           phase_reg, phase_next;
    logic [2:0]       key_pos_reg, key_pos_next;
    logic [7:0]       held_char_reg, held_char_next;
    logic             held_valid_reg, held_valid_next;
    logic [CNT_W-1:0] bytes_seen_reg, bytes_seen_next;
    logic             finished_reg, finished_next;

    res_t res_a, res_b;
    logic res_a_v, res_b_v;

    always_comb
    begin
        phase_next      = phase_reg;
        key_pos_next    = key_pos_reg;
        held_char_next  = held_char_reg;
        held_valid_next = held_valid_reg;
        bytes_seen_next = bytes_seen_reg;
        finished_next   = finished_reg;
        res_a   = '0;
        res_b   = '0;
        res_a_v = 1'b0;
        res_b_v = 1'b0;

        if (!finished_reg)
        begin
            if ((text_byte == CH_NUL) || (bytes_seen_reg >= MAX_CNT))
            begin
                // End of text: flush the held byte or report that nothing was found.
                if (held_valid_next)
                begin
                    res_a_v = 1'b1;
                    res_a   = '{path_byte: held_char_next, last_of_path: 1'b1, found: 1'b1};
                end
                else
                begin
                    res_a_v = 1'b1;
                    res_a   = '{path_byte: 8'h00, last_of_path: 1'b1, found: 1'b0};
                end
                held_valid_next = 1'b0;
                held_char_next  = 8'h00;
                finished_next   = 1'b1;
                phase_next      = PH_DONE;
            end
            else
            begin
                bytes_seen_next = bytes_seen_reg + CNT_W'(1);
                unique case (phase_reg)
                    PH_LEAD:
                    begin
                        if (is_blank(text_byte) || (text_byte == CH_LF))
                        begin
                            phase_next = PH_LEAD;
                        end
                        else if (text_byte == key_char(3'd0))
                        begin
                            key_pos_next = 3'd1;
                            phase_next   = PH_KEY;
                        end
                        else
                        begin
                            phase_next = PH_SKIP_LINE;
                        end
                    end
                    PH_KEY:
                    begin
                        if ((key_pos_reg < KEY_LEN) && (text_byte == key_char(key_pos_reg)))
                        begin
                            key_pos_next = key_pos_reg + 3'd1;
                            if (key_pos_next >= KEY_LEN)
                            begin
                                phase_next = PH_AFTER_KEY;
                            end
                        end
                        else
                        begin
                            phase_next = (text_byte == CH_LF) ? PH_LEAD : PH_SKIP_LINE;
                        end
                    end
                    PH_AFTER_KEY:
                    begin
                        if (is_blank(text_byte))
                        begin
                            phase_next = PH_AFTER_KEY;
                        end
                        else if (text_byte == CH_EQ)
                        begin
                            phase_next = PH_AFTER_EQ;
                        end
                        else
                        begin
                            phase_next = (text_byte == CH_LF) ? PH_LEAD : PH_SKIP_LINE;
                        end
                    end
                    PH_AFTER_EQ:
                    begin
                        if (is_blank(text_byte))
                        begin
                            phase_next = PH_AFTER_EQ;
                        end
                        else if (text_byte == CH_LF)
                        begin
                            phase_next = PH_LEAD;
                        end
                        else
                        begin
                            held_char_next  = text_byte;
                            held_valid_next = 1'b1;
                            phase_next      = PH_VALUE;
                        end
                    end
                    PH_VALUE:
                    begin
                        // One byte is held back so that the last mark is known when it leaves.
                        if (is_blank(text_byte) || (text_byte == CH_LF))
                        begin
                            if (held_valid_reg)
                            begin
                                res_a_v = 1'b1;
                                res_a   = '{path_byte: held_char_reg, last_of_path: 1'b1,
                                            found: 1'b1};
                            end
                            held_valid_next = 1'b0;
                            held_char_next  = 8'h00;
                            finished_next   = 1'b1;
                            phase_next      = PH_DONE;
                        end
                        else
                        begin
                            if (held_valid_reg)
                            begin
                                res_a_v = 1'b1;
                                res_a   = '{path_byte: held_char_reg, last_of_path: 1'b0,
                                            found: 1'b1};
                            end
                            held_char_next  = text_byte;
                            held_valid_next = 1'b1;
                        end
                    end
                    PH_SKIP_LINE:
                    begin
                        if (text_byte == CH_LF)
                        begin
                            phase_next = PH_LEAD;
                        end
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end

        if (final_byte)
        begin
            if (!finished_next)
            begin
                if (held_valid_next)
                begin
                    res_b_v = 1'b1;
                    res_b   = '{path_byte: held_char_next, last_of_path: 1'b1, found: 1'b1};
                end
                else
                begin
                    res_b_v = 1'b1;
                    res_b   = '{path_byte: 8'h00, last_of_path: 1'b1, found: 1'b0};
                end
            end
            phase_next      = PH_LEAD;
            key_pos_next    = 3'd0;
            held_char_next  = 8'h00;
            held_valid_next = 1'b0;
            bytes_seen_next = '0;
            finished_next   = 1'b0;
        end

        push.count  = take ? ({1'b0, res_a_v} + {1'b0, res_b_v}) : 2'd0;
        push.first  = res_a_v ? res_a : res_b;
        push.second = res_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_LEAD;
            key_pos_reg    <= 3'd0;
            held_char_reg  <= 8'h00;
            held_valid_reg <= 1'b0;
            bytes_seen_reg <= '0;
            finished_reg   <= 1'b0;
        end
        else if (take)
        begin
            phase_reg      <= phase_next;
            key_pos_reg    <= key_pos_next;
            held_char_reg  <= held_char_next;
            held_valid_reg <= held_valid_next;
            bytes_seen_reg <= bytes_seen_next;
            finished_reg   <= finished_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/bkve_out_fifo.sv -----
`default_nettype none

module bkve_out_fifo (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire bkve_pkg::push_t push,
    output logic                 room,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output bkve_pkg::res_t       out_res
);
    import bkve_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    res_t             mem [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pop;

    assign out_valid = (count_reg != '0);
    assign out_res   = mem[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    // One transfer can give two results, so two free entries are needed to take it.
    assign room      = (count_reg <= CNT_W'(FIFO_DEPTH - 2));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.count);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(push.count) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem[wr_ptr_reg + PTR_W'(1)] <= push.second;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/boot_key_value_extractor_top.sv -----
`default_nettype none

// Extracts the value of the BOOT2 key from a configuration text streamed in one
// byte per transfer (s_tlast marks the last byte of a text). Each value byte
// leaves as one output transfer, the last one with m_tlast set and m_tuser
// (found) high; a text without a usable BOOT2 line gives a single transfer
// with data zero, m_tlast high and m_tuser low. One input transfer is taken
// per cycle: the parser updates its state in the accepting cycle and writes
// its results into a four-entry output queue, and s_tready stays high while
// at least two queue entries are free, so a sink that takes every cycle never
// stalls the input. Bytes after the value or after end of text are consumed
// without results until the transfer that carries s_tlast. A zero byte, or a
// byte beyond MAX_TEXT_BYTES, ends the text.
module boot_key_value_extractor_top #(
    parameter int MAX_TEXT_BYTES = bkve_pkg::MAX_TEXT_BYTES_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] text_byte
    input  wire logic       s_tlast,   // final_byte
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] path_byte
    output logic            m_tlast,   // last_of_path
    output logic            m_tuser    // found
);
    import bkve_pkg::*;

    push_t push;
    res_t  out_res;
    logic  room;
    logic  take;

    assign s_tready = room;
    assign take     = s_tvalid && room;

    bkve_parser #(
        .MAX_TEXT_BYTES(MAX_TEXT_BYTES)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .text_byte  (s_tdata),
        .final_byte (s_tlast),
        .push       (push)
    );

    bkve_out_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = out_res.path_byte;
    assign m_tlast = out_res.last_of_path;
    assign m_tuser = out_res.found;

endmodule

`default_nettype wire

// ----- dv/boot_key_value_extractor_top_tb.sv -----
`timescale 1ns / 1ps

module boot_key_value_extractor_top_tb;

    import bkve_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 400;
    localparam logic [39:0] KEY_WORD = "BOOT2";

    typedef struct packed {
        logic [7:0] ch;
        logic       fin;
    } text_byte_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;   // [7:0] text_byte
    logic       s_tlast = 1'b0;    // final_byte
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;           // [7:0] path_byte
    logic       m_tlast;           // last_of_path
    logic       m_tuser;           // found

    boot_key_value_extractor_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #5 clk = ~clk;

    // Stimulus and expectations
    text_byte_t pending_text[$];
    res_t       expected_path[$];
    logic [7:0] draft[$];
    text_byte_t next_byte;
    res_t       want;

    int  src_idle_pct = 0;
    int  sink_stall_pct = 0;
    logic sink_hold = 1'b0;
    logic byte_taken = 1'b0;
    event hold_go;

    int mismatch_count = 0;
    int idle_cycles = 0;
    int bytes_in = 0;
    int texts_in = 0;
    int results_checked = 0;
    int values_found = 0;
    int values_missing = 0;

    // Scanner state mirrored by the predictor
    phase_t      scan_phase = PH_LEAD;
    logic [2:0]  key_pos = '0;
    logic [7:0]  held_ch = '0;
    logic        held_ok = 1'b0;
    int unsigned text_count = 0;
    logic        text_done = 1'b0;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR);
    endfunction

    function automatic logic [7:0] key_at(input logic [2:0] p);
        return KEY_WORD[8 * (4 - int'(p)) +: 8];
    endfunction

    function automatic void clear_scanner();
        scan_phase = PH_LEAD;
        key_pos    = '0;
        held_ch    = '0;
        held_ok    = 1'b0;
        text_count = 0;
        text_done  = 1'b0;
    endfunction

    function automatic void expect_path(input logic [7:0] ch, input logic last,
                                        input logic fnd);
        res_t r;
        r.path_byte    = ch;
        r.last_of_path = last;
        r.found        = fnd;
        expected_path.push_back(r);
    endfunction

    function automatic void close_text();
        if (held_ok)
            expect_path(held_ch, 1'b1, 1'b1);
        else if (!text_done)
            expect_path(8'h00, 1'b1, 1'b0);
        held_ok    = 1'b0;
        held_ch    = '0;
        text_done  = 1'b1;
        scan_phase = PH_DONE;
    endfunction

    function automatic void scan_char(input logic [7:0] c);
        case (scan_phase)
            PH_LEAD:
                if (is_ws(c) || c == CH_LF)
                begin
                    // leading whitespace and empty lines are skipped
                end
                else if (c == key_at(3'd0))
                begin
                    key_pos    = 3'd1;
                    scan_phase = PH_KEY;
                end
                else
                begin
                    scan_phase = PH_SKIP_LINE;
                end
            PH_KEY:
                if (key_pos < KEY_LEN && c == key_at(key_pos))
                begin
                    key_pos = key_pos + 3'd1;
                    if (key_pos >= KEY_LEN)
                        scan_phase = PH_AFTER_KEY;
                end
                else
                begin
                    scan_phase = (c == CH_LF) ? PH_LEAD : PH_SKIP_LINE;
                end
            PH_AFTER_KEY:
                if (is_ws(c))
                begin
                end
                else if (c == CH_EQ)
                begin
                    scan_phase = PH_AFTER_EQ;
                end
                else
                begin
                    scan_phase = (c == CH_LF) ? PH_LEAD : PH_SKIP_LINE;
                end
            PH_AFTER_EQ:
                if (is_ws(c))
                begin
                end
                else if (c == CH_LF)
                begin
                    scan_phase = PH_LEAD;
                end
                else
                begin
                    held_ch    = c;
                    held_ok    = 1'b1;
                    scan_phase = PH_VALUE;
                end
            PH_VALUE:
                if (is_ws(c) || c == CH_LF)
                begin
                    if (held_ok)
                        expect_path(held_ch, 1'b1, 1'b1);
                    held_ok    = 1'b0;
                    held_ch    = '0;
                    text_done  = 1'b1;
                    scan_phase = PH_DONE;
                end
                else
                begin
                    // The previous byte is sent only once it is known not to be the last.
                    if (held_ok)
                        expect_path(held_ch, 1'b0, 1'b1);
                    held_ch = c;
                    held_ok = 1'b1;
                end
            PH_SKIP_LINE:
                if (c == CH_LF)
                    scan_phase = PH_LEAD;
            default:
            begin
            end
        endcase
    endfunction

    function automatic void predict_text_byte(input logic [7:0] c, input logic fin);
        if (!text_done)
        begin
            if (c == CH_NUL || text_count >= MAX_TEXT_BYTES_DEF)
            begin
                close_text();
            end
            else
            begin
                text_count++;
                scan_char(c);
            end
        end
        if (fin)
        begin
            if (!text_done)
                close_text();
            clear_scanner();
        end
    endfunction

    task automatic note_mismatch(input string what);
        mismatch_count++;
        $display("[%0t] MISMATCH: %s", $time, what);
    endtask

    // Text construction helpers
    function automatic logic [7:0] pick_value_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(1, 255));
        while (is_ws(c) || c == CH_LF);
        return c;
    endfunction

    function automatic logic [7:0] pick_ws();
        case ($urandom_range(0, 2))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            default: return CH_CR;
        endcase
    endfunction

    function automatic void add_ws(input int max_n);
        int n;
        n = $urandom_range(0, max_n);
        repeat (n) draft.push_back(pick_ws());
    endfunction

    function automatic void add_str(input string s);
        for (int i = 0; i < s.len(); i++)
            draft.push_back(s[i]);
    endfunction

    function automatic void add_value_line(input int vlen);
        add_ws(2);
        add_str("BOOT2");
        add_ws(2);
        draft.push_back(CH_EQ);
        add_ws(2);
        repeat (vlen) draft.push_back(pick_value_char());
    endfunction

    // The whole draft becomes one text; the final byte carries tlast.
    function automatic void flush_text();
        text_byte_t t;
        for (int i = 0; i < draft.size(); i++)
        begin
            t.ch  = draft[i];
            t.fin = (i == draft.size() - 1);
            pending_text.push_back(t);
        end
        draft.delete();
    endfunction

    function automatic void add_random_text();
        int n_lines;
        int pos;
        logic [7:0] c;
        n_lines = $urandom_range(1, 3);
        for (int ln = 0; ln < n_lines; ln++)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4:
                begin
                    add_value_line($urandom_range(1, 6));
                    case ($urandom_range(0, 3))
                        0:       draft.push_back(CH_LF);
                        1:       draft.push_back(pick_ws());
                        2:
                        begin
                        end
                        default:
                        begin
                            add_ws(1);
                            draft.push_back(CH_LF);
                        end
                    endcase
                end
                5:
                begin
                    // key damaged in one place, or '=' replaced
                    pos = $urandom_range(0, 5);
                    add_ws(1);
                    for (int k = 0; k < 6; k++)
                    begin
                        c = (k < 5) ? key_at(3'(k)) : CH_EQ;
                        if (k == pos)
                            c = c ^ 8'($urandom_range(1, 255));
                        draft.push_back(c);
                    end
                    draft.push_back(pick_value_char());
                    draft.push_back(CH_LF);
                end
                6:
                begin
                    add_str("BOOT2");
                    add_ws(2);
                    draft.push_back(CH_EQ);
                    add_ws(2);
                    draft.push_back(CH_LF);
                end
                7:
                begin
                    repeat ($urandom_range(1, 8)) draft.push_back(8'($urandom_range(1, 255)));
                    draft.push_back(CH_LF);
                end
                8:
                begin
                    add_ws(3);
                    draft.push_back(CH_LF);
                end
                default:
                    repeat ($urandom_range(1, 10)) draft.push_back(8'($urandom_range(0, 255)));
            endcase
        end
        case ($urandom_range(0, 3))
            1:
            begin
                draft.push_back(CH_NUL);
                repeat ($urandom_range(0, 2)) draft.push_back(8'($urandom_range(0, 255)));
            end
            2: repeat ($urandom_range(1, 3)) draft.push_back(8'($urandom_range(0, 255)));
            default:
            begin
            end
        endcase
        flush_text();
    endfunction

    function automatic void add_random_texts(input int n_items);
        int start;
        start = pending_text.size();
        while (pending_text.size() - start < n_items)
            add_random_text();
    endfunction

    // Junk that keeps the scanner in the skipped-line state.
    function automatic void add_junk(input int n);
        draft.push_back("x");
        repeat (n - 1)
        begin
            logic [7:0] c;
            do
                c = 8'($urandom_range(1, 255));
            while (c == CH_LF);
            draft.push_back(c);
        end
    endfunction

    task automatic wait_drained();
        while (pending_text.size() != 0 || s_tvalid || expected_path.size() != 0)
            @(posedge clk);
    endtask

    // Sender and receiver, both changing at the falling edge
    always @(negedge clk)
    begin
        if (!s_tvalid || byte_taken)
        begin
            if (rst_n && pending_text.size() != 0 &&
                $urandom_range(0, 99) >= src_idle_pct)
            begin
                next_byte = pending_text.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= next_byte.ch;
                s_tlast  <= next_byte.fin;
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
        m_tready <= rst_n && !sink_hold && ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // Long receiver hold-off so that the output queue fills and input stalls.
    always
    begin
        @(hold_go);
        sink_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        sink_hold = 1'b0;
    end

    // Monitor: predict on every accepted input transfer, check every output transfer.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            byte_taken <= s_tvalid && s_tready;
            if (s_tvalid && s_tready)
            begin
                bytes_in++;
                if (s_tlast)
                    texts_in++;
                predict_text_byte(s_tdata, s_tlast);
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_path.size() == 0)
                begin
                    note_mismatch($sformatf({"result with none expected: ",
                                             "data=%02h last=%0b found=%0b"},
                                            m_tdata, m_tlast, m_tuser));
                end
                else
                begin
                    want = expected_path.pop_front();
                    results_checked++;
                    if (want.last_of_path && want.found)
                        values_found++;
                    if (!want.found)
                        values_missing++;
                    if (m_tdata !== want.path_byte || m_tlast !== want.last_of_path ||
                        m_tuser !== want.found)
                        note_mismatch($sformatf({"data=%02h last=%0b found=%0b, ",
                                                 "expected data=%02h last=%0b found=%0b"},
                                                m_tdata, m_tlast, m_tuser, want.path_byte,
                                                want.last_of_path, want.found));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("boot_key_value_extractor_top regression: fail");
            $finish;
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed texts, no idling
        add_str("\t BOOT2\r= xy\n");
        draft.push_back(8'hFF);
        flush_text();
        add_str("BOO\nBOOT2 x\nBOOT2 =\r\nBOOT2=pq");
        flush_text();
        draft.push_back(CH_NUL);
        flush_text();
        add_str("BOOT2");
        draft.push_back(CH_NUL);
        add_str("z");
        flush_text();
        add_str("A=1");
        flush_text();
        add_str("BOOT2=v");
        draft.push_back(CH_NUL);
        flush_text();
        wait_drained();

        add_random_texts(100);
        wait_drained();

        src_idle_pct = 46;
        add_random_texts(100);
        wait_drained();

        src_idle_pct   = 0;
        sink_stall_pct = 46;
        add_random_texts(100);
        wait_drained();

        src_idle_pct   = 15;
        sink_stall_pct = 15;
        add_random_texts(100);
        wait_drained();

        // Receiver held off while long values keep arriving.
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        @(negedge clk);
        -> hold_go;
        repeat (3)
        begin
            add_value_line(20);
            draft.push_back(CH_LF);
            flush_text();
        end
        wait_drained();

        // A text running past the length limit, whose last value byte sits
        // exactly on the limit.
        add_junk(MAX_TEXT_BYTES_DEF - 10);
        draft.push_back(CH_LF);
        add_str("BOOT2=");
        repeat (3) draft.push_back(pick_value_char());
        add_str("Zq");
        flush_text();
        wait_drained();

        repeat (20) @(posedge clk);
        if (expected_path.size() != 0)
            note_mismatch($sformatf("%0d expected results never arrived",
                                    expected_path.size()));

        $display("Covered %0d texts in %0d input transfers; %0d results checked,",
                 texts_in, bytes_in, results_checked);
        $display("%0d values found, %0d not-found results, with idling, a hold-off and the limit.",
                 values_found, values_missing);
        if (mismatch_count == 0)
            $display("boot_key_value_extractor_top regression: pass");
        else
            $display("boot_key_value_extractor_top regression: fail");
        $finish;
    end

endmodule

// ----- boot_key_value_extractor_top.f -----
rtl/bkve_pkg.sv
rtl/bkve_parser.sv
rtl/bkve_out_fifo.sv
rtl/boot_key_value_extractor_top.sv
dv/boot_key_value_extractor_top_tb.sv
